@@ rtl/u2u_pkg.sv @@
`default_nettype none

package u2u_pkg;

  // One input word: a raw UTF-8 byte and the end-of-string mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  // One output word: a 16-bit code unit and its flags.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_terminator;
    logic        truncated;
    logic        last;
  } out_item_t;

  // Results of one decoded byte, handed from the decoder to the output queue.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  // Lead byte thresholds.
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadTwo   = 8'hC0;

  // Payload masks for lead and continuation bytes.
  localparam logic [7:0] MaskFour  = 8'h07;
  localparam logic [7:0] MaskThree = 8'h0F;
  localparam logic [7:0] MaskTwo   = 8'h1F;
  localparam logic [7:0] MaskCont  = 8'h3F;

  // Output queue depth: room for the two results of one byte plus two stored words.
  localparam int unsigned QueueDepth = 4;

endpackage

`default_nettype wire

@@ rtl/utf8_to_utf16_decoder.sv @@
// Each byte passes through the input register and then the output queue storage
// before its result word is offered; it waits in the input register without room.
// Throughput: one byte per cycle while the output queue has room; a byte marked end
// of string yields two words, which the output side hands out one at a time.
// The bound is the output queue, which takes a byte only with room for two words.
// Reset (rst_ni low, asynchronous) empties the queue and clears the sequence state.
`default_nettype none

module utf8_to_utf16_decoder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire u2u_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output u2u_pkg::out_item_t      out_data_o
);

  u2u_pkg::push_t push;
  logic           room;

  // Byte decoder with its input register and sequence state.
  u2u_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .room_i     (room),
    .push_o     (push)
  );

  // Output queue that hands out one word at a time.
  u2u_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/u2u_decode.sv @@
`default_nettype none

module u2u_decode (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire u2u_pkg::in_item_t in_data_i,
  input  wire logic             room_i,
  output u2u_pkg::push_t        push_o
);

  logic              in_valid_q;
  u2u_pkg::in_item_t in_item_q;
  logic [1:0]        pend_q, pend_d;
  logic [15:0]       part_q, part_d;
  logic              fire;
  logic              unit_ready;
  logic [15:0]       unit;
  logic [15:0]       trunc_value;
  logic [7:0]        b;
  logic              eos;

  // The input register holds a byte until the output queue has room for its results.
  assign fire       = in_valid_q && room_i;
  assign in_stall_o = in_valid_q && !room_i;
  assign b          = in_item_q.in_byte;
  assign eos        = in_item_q.end_of_string;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_item_q <= in_data_i;
    end
  end

  // Sequence state: continuation bytes still expected and the bits gathered so far.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= 16'd0;
    end else if (fire) begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

  // Decode one byte against the current sequence state.
  always_comb begin
    pend_d     = pend_q;
    part_d     = part_q;
    unit_ready = 1'b0;
    unit       = 16'd0;
    if (pend_q != 2'd0) begin
      part_d = {part_q[9:0], 6'(b & u2u_pkg::MaskCont)};
      pend_d = pend_q - 2'd1;
      if (pend_d == 2'd0) begin
        unit       = part_d;
        unit_ready = 1'b1;
      end
    end else if (b >= u2u_pkg::LeadFour) begin
      // The lead bits of a four-byte sequence fall above bit 15.
      part_d = 16'(b & u2u_pkg::MaskFour) & 16'd0;
      pend_d = 2'd3;
    end else if (b >= u2u_pkg::LeadThree) begin
      part_d = 16'(b & u2u_pkg::MaskThree);
      pend_d = 2'd2;
    end else if (b >= u2u_pkg::LeadTwo) begin
      part_d = 16'(b & u2u_pkg::MaskTwo);
      pend_d = 2'd1;
    end else begin
      unit       = {8'd0, b};
      unit_ready = 1'b1;
    end

    // An early end pads each missing continuation byte with zeros.
    case (pend_d)
      2'd1:    trunc_value = {part_d[9:0], 6'd0};
      2'd2:    trunc_value = {part_d[3:0], 12'd0};
      default: trunc_value = 16'd0;
    endcase

    if (eos) begin
      pend_d = 2'd0;
      part_d = 16'd0;
    end
  end

  // Build the result words for the output queue.
  always_comb begin
    push_o = '0;
    if (fire) begin
      if (unit_ready) begin
        push_o.first.code_unit = unit;
        if (eos) begin
          push_o.count                = 2'd2;
          push_o.second.is_terminator = 1'b1;
          push_o.second.last          = 1'b1;
        end else begin
          push_o.count = 2'd1;
        end
      end else if (eos) begin
        push_o.count                = 2'd2;
        push_o.first.code_unit      = trunc_value;
        push_o.first.truncated      = 1'b1;
        push_o.second.is_terminator = 1'b1;
        push_o.second.truncated     = 1'b1;
        push_o.second.last          = 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // A string end always yields a unit and then the terminator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && eos |-> push_o.count == 2'd2 && push_o.second.is_terminator)
    else $error("end of string did not produce two words");

  // The sequence state is cleared after a string end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && eos |=> pend_q == 2'd0 && part_q == 16'd0)
    else $error("sequence state not cleared after end of string");

  // Nothing is pushed while no byte is decoded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |-> push_o.count == 2'd0)
    else $error("push without a decoded byte");
`endif

endmodule

`default_nettype wire

@@ rtl/u2u_out_fifo.sv @@
`default_nettype none

module u2u_out_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire u2u_pkg::push_t   push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output u2u_pkg::out_item_t    out_data_o
);

  localparam int unsigned Depth = u2u_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  u2u_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q, count_d;
  logic               pop;

  // Room for a full pair of results, judged on the stored count alone.
  assign room_o      = count_q <= CntW'(Depth - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign count_d     = count_q + CntW'(push_i.count) - CntW'(pop);

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

  // Result storage: one or two words written per decoded byte.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.second;
    end
  end

`ifndef SYNTHESIS
  // The fill count never exceeds the storage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("output queue overflow");

  // Words are pushed only when room was reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o)
    else $error("push without room");

  // A terminator word is always the last word of its string and has a zero code unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_terminator |-> out_data_o.last
      && out_data_o.code_unit == 16'd0)
    else $error("malformed terminator word");
`endif

endmodule

`default_nettype wire
